// ===== src/ctes_pkg.sv =====
// Package with item types, constants and the month table for the calendar-to-epoch unit.
`default_nettype none

package ctes_pkg;

    typedef struct packed {
        logic signed [15:0] second;
        logic signed [15:0] minute;
        logic signed [15:0] hour_of_day;
        logic signed [15:0] day_of_month;
        logic signed [15:0] month_index;
        logic signed [15:0] years_since_1900;
    } t_in_item;

    typedef struct packed {
        logic [37:0] epoch_seconds;
        logic        overflow;
    } t_out_item;

    localparam int NUM_STAGES = 7;

    localparam int EPOCH_YEAR    = 1970;
    localparam int BASE_YEAR     = 1900;
    localparam int MIN_YEAR_OFS  = EPOCH_YEAR - BASE_YEAR;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTHS        = 12;
    localparam int CENTURY       = 100;

    // Reciprocals: floor(x / 12) = (x * RECIP12) >> 19 for x below 2^15,
    // floor(x / 100) = (x * RECIP100) >> 22 for x below 40000.
    localparam int RECIP12       = 43691;
    localparam int RECIP12_SHIFT = 19;
    localparam int RECIP100      = 41944;
    localparam int RECIP100_SHIFT = 22;

    localparam int LEAPS_1969 = 1969 / 4 - 1969 / 100 + 1969 / 400;

    localparam logic [37:0] LAST_SECOND = 38'd253402300799;

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

// ===== src/calendar_time_to_epoch_seconds_unit.sv =====
// Pipelined conversion of broken-down UTC calendar time to seconds since 1970.
//
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_ready  i_in_data  (t_in_item)
// out      output     o_out_valid / i_out_ready o_out_data (t_out_item)
//
// Seven register stages; the last one is the output register.
// One item is accepted per cycle while the output side takes results.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// and a stall at the output holds every item in place.
// Reset empties all stages; payload registers are not reset.
`default_nettype none

module calendar_time_to_epoch_seconds_unit import ctes_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] adv;

    always_comb begin
        adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: field checks, month divided by twelve, time-of-day products.
    logic [30:0] q12_prod;
    logic        n1_bad;
    logic [11:0] r1_q;
    logic [14:0] r1_mon;
    logic [14:0] r1_yr;
    logic [14:0] r1_mday;
    logic [26:0] r1_hsec;
    logic [21:0] r1_msec;
    logic        r1_bad;

    assign q12_prod = 31'(i_in_data.month_index[14:0]) * 31'(RECIP12);

    always_comb begin
        n1_bad = i_in_data.second[15] || i_in_data.minute[15] || i_in_data.hour_of_day[15]
              || i_in_data.month_index[15]
              || (i_in_data.years_since_1900 < 16'(MIN_YEAR_OFS))
              || (i_in_data.day_of_month < 16'sd1);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_q    <= q12_prod[RECIP12_SHIFT +: 12];
            r1_mon  <= i_in_data.month_index[14:0];
            r1_yr   <= i_in_data.years_since_1900[14:0];
            r1_mday <= i_in_data.day_of_month[14:0];
            r1_hsec <= 27'(i_in_data.hour_of_day[14:0]) * 27'(SECS_PER_HOUR);
            r1_msec <= 22'(i_in_data.minute[14:0]) * 22'(SECS_PER_MIN)
                     + 22'(i_in_data.second[14:0]);
            r1_bad  <= n1_bad;
        end
    end

    // Stage 2: month remainder, full year, seconds within the day.
    logic [14:0] mon_rem_full;
    logic [3:0]  r2_rem;
    logic [15:0] r2_year;
    logic [26:0] r2_hms;
    logic [14:0] r2_mday;
    logic        r2_bad;

    assign mon_rem_full = r1_mon - 15'(r1_q) * 15'(MONTHS);

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r2_rem  <= mon_rem_full[3:0];
            r2_year <= 16'(r1_yr) + 16'(BASE_YEAR) + 16'(r1_q);
            r2_hms  <= r1_hsec + 27'(r1_msec);
            r2_mday <= r1_mday;
            r2_bad  <= r1_bad;
        end
    end

    // Stage 3: previous year divided by one hundred.
    logic [15:0] prev_year;
    logic [31:0] q100_prod;
    logic [15:0] r3_n;
    logic [8:0]  r3_q100;
    logic [3:0]  r3_rem;
    logic [26:0] r3_hms;
    logic [14:0] r3_mday;
    logic        r3_bad;

    assign prev_year = r2_year - 16'd1;
    assign q100_prod = 32'(prev_year) * 32'(RECIP100);

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r3_n    <= prev_year;
            r3_q100 <= q100_prod[RECIP100_SHIFT +: 9];
            r3_rem  <= r2_rem;
            r3_hms  <= r2_hms;
            r3_mday <= r2_mday;
            r3_bad  <= r2_bad;
        end
    end

    // Stage 4: leap count, leap flag, whole-year days and days within the year.
    logic [6:0]  rem100;
    logic        is_leap;
    logic [13:0] r4_leaps;
    logic [23:0] r4_ydays;
    logic [15:0] r4_mdays;
    logic [26:0] r4_hms;
    logic        r4_bad;

    assign rem100  = 7'(r3_n - 16'(r3_q100) * 16'(CENTURY));
    assign is_leap = (r3_n[1:0] == 2'd3)
                  && ((rem100 != 7'(CENTURY - 1)) || (r3_q100[1:0] == 2'd3));

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r4_leaps <= 14'(r3_n >> 2) - 14'(r3_q100) + 14'(r3_q100 >> 2) - 14'(LEAPS_1969);
            r4_ydays <= 24'(r3_n - 16'(EPOCH_YEAR - 1)) * 24'(DAYS_PER_YEAR);
            r4_mdays <= 16'(month_start(r3_rem)) + 16'((r3_rem > 4'd1) && is_leap)
                      + 16'(r3_mday) - 16'd1;
            r4_hms   <= r3_hms;
            r4_bad   <= r3_bad;
        end
    end

    // Stage 5: day count since the epoch.
    logic [23:0] r5_days;
    logic [26:0] r5_hms;
    logic        r5_bad;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r5_days <= r4_ydays + 24'(r4_leaps) + 24'(r4_mdays);
            r5_hms  <= r4_hms;
            r5_bad  <= r4_bad;
        end
    end

    // Stage 6: days to seconds.
    logic [40:0] r6_dsec;
    logic [26:0] r6_hms;
    logic        r6_bad;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r6_dsec <= 41'(r5_days) * 41'(SECS_PER_DAY);
            r6_hms  <= r5_hms;
            r6_bad  <= r5_bad;
        end
    end

    // Stage 7: total, range check and output register.
    logic [41:0] total;
    t_out_item   n_out;
    t_out_item   r_out;

    always_comb begin
        total = 42'(r6_dsec) + 42'(r6_hms);
        n_out.overflow = r6_bad || (total > 42'(LAST_SECOND));
        n_out.epoch_seconds = n_out.overflow ? '0 : total[37:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire
